// ===== hdl/psc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, codes and helper functions for the padded string compare.
// ----------------------------------------------------------------------------
package psc_pkg;

    // character and field widths
    localparam int CHAR_W     = 32;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    // three-way order, two-bit signed
    typedef logic signed [1:0] order_t;

    localparam order_t ORD_LESS    = 2'sb11;
    localparam order_t ORD_EQUAL   = 2'sb00;
    localparam order_t ORD_GREATER = 2'sb01;

    // relation codes
    localparam logic [OP_W-1:0] OP_EQ = 3'd0;
    localparam logic [OP_W-1:0] OP_NE = 3'd1;
    localparam logic [OP_W-1:0] OP_LT = 3'd2;
    localparam logic [OP_W-1:0] OP_LE = 3'd3;
    localparam logic [OP_W-1:0] OP_GT = 3'd4;
    localparam logic [OP_W-1:0] OP_GE = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_OP     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_TRAILING = 1'd1;

    // whitespace and nul characters
    localparam logic [CHAR_W-1:0] CH_NUL   = 32'h0000_0000;
    localparam logic [CHAR_W-1:0] CH_TAB   = 32'h0000_0009;
    localparam logic [CHAR_W-1:0] CH_LF    = 32'h0000_000A;
    localparam logic [CHAR_W-1:0] CH_VT    = 32'h0000_000B;
    localparam logic [CHAR_W-1:0] CH_FF    = 32'h0000_000C;
    localparam logic [CHAR_W-1:0] CH_CR    = 32'h0000_000D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 32'h0000_0020;

    // one character position of both strings
    typedef struct packed {
        logic [CHAR_W-1:0] char_a;
        logic [CHAR_W-1:0] char_b;
        logic              last;
    } psc_item_t;

    // character may be dropped from a trailing run
    function automatic logic is_strippable(input logic [CHAR_W-1:0] c);
        return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    endfunction

    // unsigned three-way compare
    function automatic order_t order_of(input logic [CHAR_W-1:0] x,
                                        input logic [CHAR_W-1:0] y);
        order_t o;
        if (x < y)
        begin
            o = ORD_LESS;
        end
        else if (x > y)
        begin
            o = ORD_GREATER;
        end
        else
        begin
            o = ORD_EQUAL;
        end
        return o;
    endfunction

    // truth of the selected relation; unknown codes give false
    function automatic logic relation_holds(input logic [OP_W-1:0] op, input order_t o);
        logic r;
        case (op)
            OP_EQ:   r = (o == ORD_EQUAL);
            OP_NE:   r = (o != ORD_EQUAL);
            OP_LT:   r = (o == ORD_LESS);
            OP_LE:   r = (o != ORD_GREATER);
            OP_GT:   r = (o == ORD_GREATER);
            OP_GE:   r = (o != ORD_LESS);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/psc_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psc_in_if
// Character position channel: valid/ready with both characters and last flag.
// ----------------------------------------------------------------------------
interface psc_in_if
    import psc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_a;
    logic [CHAR_W-1:0] char_b;
    logic              last;

    modport source (output valid, output char_a, output char_b, output last, input ready);
    modport sink   (input valid, input char_a, input char_b, input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/psc_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psc_out_if
// Result channel: valid/ready with the order and the relation flag.
// ----------------------------------------------------------------------------
interface psc_out_if
    import psc_pkg::*;
();
    logic   valid;
    logic   ready;
    order_t order;
    logic   relation_true;

    modport source (output valid, output order, output relation_true, input ready);
    modport sink   (input valid, input order, input relation_true, output ready);
endinterface
`default_nettype wire

// ===== hdl/psc_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psc_tracker
// Per-string compare state: plain order and the four strip-run hypotheses.
// ----------------------------------------------------------------------------
module psc_tracker
    import psc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire psc_item_t item,
    input  wire logic      strip_trailing,
    output order_t         final_order
);

    logic   first_reg;
    logic   first_next;
    order_t settled_reg;
    order_t settled_next;
    order_t tent_reg [4];
    order_t tent_next [4];
    order_t tent_upd [4];

    logic   sa;
    logic   sb;
    order_t ord_both;
    order_t ord_a_zero;
    order_t ord_b_zero;

    // strip-run membership, never at the first position
    assign sa = !first_reg && is_strippable(item.char_a);
    assign sb = !first_reg && is_strippable(item.char_b);

    // the three compares of this position
    assign ord_both   = order_of(item.char_a, item.char_b);
    assign ord_a_zero = (item.char_b != CH_NUL) ? ORD_LESS : ORD_EQUAL;
    assign ord_b_zero = (item.char_a != CH_NUL) ? ORD_GREATER : ORD_EQUAL;

    // hypothesis update: a broken run discards the stripped assumption
    always_comb
    begin
        order_t t [4];
        order_t c [4];
        t = tent_reg;
        if (!sa)
        begin
            t[2] = t[0];
            t[3] = t[1];
        end
        if (!sb)
        begin
            t[1] = t[0];
            t[3] = t[2];
        end
        c[0] = ord_both;
        c[1] = sb ? ord_b_zero : ord_both;
        c[2] = sa ? ord_a_zero : ord_both;
        c[3] = (sa && sb) ? ORD_EQUAL : (sa ? ord_a_zero : (sb ? ord_b_zero : ord_both));
        for (int k = 0; k < 4; k++)
        begin
            tent_upd[k] = (t[k] == ORD_EQUAL) ? c[k] : t[k];
        end
    end

    assign settled_next = (settled_reg == ORD_EQUAL) ? ord_both : settled_reg;
    assign final_order  = strip_trailing ? tent_upd[3] : settled_next;

    // next state, cleared after the last position
    always_comb
    begin
        first_next = first_reg;
        tent_next  = tent_reg;
        if (step)
        begin
            if (item.last)
            begin
                first_next = 1'b1;
                for (int k = 0; k < 4; k++)
                begin
                    tent_next[k] = ORD_EQUAL;
                end
            end
            else
            begin
                first_next = 1'b0;
                tent_next  = tent_upd;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg   <= 1'b1;
            settled_reg <= ORD_EQUAL;
            for (int k = 0; k < 4; k++)
            begin
                tent_reg[k] <= ORD_EQUAL;
            end
        end
        else
        begin
            first_reg <= first_next;
            tent_reg  <= tent_next;
            if (step)
            begin
                settled_reg <= item.last ? ORD_EQUAL : settled_next;
            end
        end
    end

    // a string pair ends back at the first position
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last |=> first_reg && settled_reg == ORD_EQUAL)
        else $error("state not cleared after last position");

    // any inner position leaves the first-position flag low
    a_inner_step: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.last |=> !first_reg)
        else $error("first-position flag set after inner position");

    // a decided plain order stays until the string ends
    a_settled_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.last && settled_reg != ORD_EQUAL |=> settled_reg == $past(settled_reg))
        else $error("settled order changed mid-string");

endmodule
`default_nettype wire

// ===== hdl/padded_string_compare_core.sv =====
// a last position accepted into the input register moves on to the result register unless an untaken result blocks it
// throughput: one character position per cycle, sustained, under continuous ready
// set by the single state-update stage between the input and result registers
// reset: rst_n asynchronous active low; clears valids, compare state and configuration registers
// compare_op and strip_trailing reset to 0 (equal, no stripping)
`default_nettype none
// ----------------------------------------------------------------------------
// padded_string_compare_core
// Streaming lexicographic compare of two zero-padded strings with optional
// trailing whitespace strip; one result per string pair.
// ----------------------------------------------------------------------------
module padded_string_compare_core
    import psc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    psc_in_if.sink                     items,
    psc_out_if.source                  results,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [OP_W-1:0] compare_op_reg;
    logic            strip_trailing_reg;

    logic            s1_valid_reg;
    psc_item_t       s1_item_reg;
    logic            s1_go;

    logic            out_valid_reg;
    order_t          order_reg;
    logic            relation_reg;
    logic            out_free;

    order_t          final_order;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_op_reg     <= OP_EQ;
            strip_trailing_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COMPARE_OP:     compare_op_reg     <= cfg_data[OP_W-1:0];
                CFG_STRIP_TRAILING: strip_trailing_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // handshake: a position moves on unless it is last and the result is blocked
    assign out_free    = !out_valid_reg || results.ready;
    assign s1_go       = s1_valid_reg && (!s1_item_reg.last || out_free);
    assign items.ready = !s1_valid_reg || s1_go;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            s1_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.ready && items.valid)
        begin
            s1_item_reg.char_a <= items.char_a;
            s1_item_reg.char_b <= items.char_b;
            s1_item_reg.last   <= items.last;
        end
    end

    // compare state
    psc_tracker u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (s1_go),
        .item           (s1_item_reg),
        .strip_trailing (strip_trailing_reg),
        .final_order    (final_order)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_item_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_item_reg.last)
        begin
            order_reg    <= final_order;
            relation_reg <= relation_holds(compare_op_reg, final_order);
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.order         = order_reg;
    assign results.relation_true = relation_reg;

    // a new result only comes from a last position
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_item_reg.last))
        else $error("result raised without a last position");

    // a stalled position is kept intact in the input register
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("stalled position lost or changed");

    // a last position never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_item_reg.last |-> !out_valid_reg || results.ready)
        else $error("result overwritten before transaction");

endmodule
`default_nettype wire
